// File: rtl/bgi_pkg.sv
// Types and constants shared by the bilinear grid interpolator.
`timescale 1ns / 1ps
package bgi_pkg;

    localparam int CFG_IDX_W = 3;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LAT_ORIGIN = 3'd0,
        CFG_LON_ORIGIN = 3'd1,
        CFG_LAT_SCALE  = 3'd2,
        CFG_LON_SCALE  = 3'd3,
        CFG_ROWS_USED  = 3'd4,
        CFG_COLS_USED  = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic               opcode;
        logic [5:0]         cell_row;
        logic [5:0]         cell_col;
        logic signed [15:0] cell_value;
        logic signed [31:0] query_lat;
        logic signed [31:0] query_lon;
    } bgi_in_t;

    typedef struct packed {
        logic signed [23:0] value;
        logic signed [31:0] grad_lat;
        logic signed [31:0] grad_lon;
        logic               in_bounds;
        logic               is_write_ack;
    } bgi_out_t;

endpackage

// File: rtl/bilinear_grid_interpolator.sv
// Bilinear grid interpolator with gradients: ten-stage pipeline over a banked grid memory.
`timescale 1ns / 1ps
// Usage:
//   s_valid/s_ready/s_data carry requests: opcode 0 writes one grid cell, opcode 1
//   queries a position. Every request yields exactly one result on m_valid/m_ready/
//   m_data, in order: a write acknowledgement or an interpolated value with gradients.
//   cfg_wr_en/cfg_index/cfg_wdata write the origin, scale and grid size registers;
//   write them only while no request is in flight.
//   One request is accepted every cycle while the receiver does not stall; the grid
//   is split into four banks by row and column parity so the four corner cells are
//   read in the same cycle, one port per bank.
//   A write lands in the grid in stage 4, so a query right behind it sees the new cell.
//   When the receiver stalls, the whole pipeline holds and s_ready drops; nothing is
//   lost or repeated. A stalled result stays on m_data.
//   Reset (aresetn low, synchronous) empties the pipeline and restores the registers;
//   the grid contents are undefined until written and there is no clearing pass.
module bilinear_grid_interpolator #(
    parameter int MAX_ROWS    = 64,
    parameter int MAX_COLS    = 64,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [bgi_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [31:0]                    cfg_wdata,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  bgi_pkg::bgi_in_t               s_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output bgi_pkg::bgi_out_t              m_data
);
    import bgi_pkg::*;

    localparam int SW     = SAMPLE_BITS;
    localparam int IWR    = $clog2(MAX_ROWS);
    localparam int IWC    = $clog2(MAX_COLS);
    localparam int NRW    = $clog2(MAX_ROWS + 1);
    localparam int NCW    = $clog2(MAX_COLS + 1);
    localparam int BR     = (MAX_ROWS + 1) / 2;
    localparam int BC     = (MAX_COLS + 1) / 2;
    localparam int RHW    = (BR > 1) ? $clog2(BR) : 1;
    localparam int CHW    = (BC > 1) ? $clog2(BC) : 1;
    localparam int BAW    = RHW + CHW;
    localparam int BDEPTH = 1 << BAW;
    localparam int AW     = SW + 21;
    localparam int VW     = SW + 40;
    localparam int GW     = AW + 33;
    localparam int VQW    = VW - 23;
    localparam int GQW    = GW - 24;
    localparam int STAGES = 10;

    // configuration
    logic signed [31:0] lat_origin_reg, lon_origin_reg;
    logic [31:0]        lat_scale_reg, lon_scale_reg;
    logic [6:0]         rows_used_reg, cols_used_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lat_origin_reg <= '0;
            lon_origin_reg <= '0;
            lat_scale_reg  <= 32'd65536;
            lon_scale_reg  <= 32'd65536;
            rows_used_reg  <= 7'd64;
            cols_used_reg  <= 7'd64;
        end else if (cfg_wr_en) begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_LAT_ORIGIN: lat_origin_reg <= cfg_wdata;
                CFG_LON_ORIGIN: lon_origin_reg <= cfg_wdata;
                CFG_LAT_SCALE:  lat_scale_reg  <= cfg_wdata;
                CFG_LON_SCALE:  lon_scale_reg  <= cfg_wdata;
                CFG_ROWS_USED:  rows_used_reg  <= cfg_wdata[6:0];
                CFG_COLS_USED:  cols_used_reg  <= cfg_wdata[6:0];
                default: ;
            endcase
        end
    end

    logic [NRW-1:0] rows_eff, rows_nm1;
    logic [NCW-1:0] cols_eff, cols_nm1;

    always_comb begin
        if (rows_used_reg < 7'd2) begin
            rows_eff = NRW'(2);
        end else if (int'(rows_used_reg) > MAX_ROWS) begin
            rows_eff = NRW'(MAX_ROWS);
        end else begin
            rows_eff = NRW'(rows_used_reg);
        end
        if (cols_used_reg < 7'd2) begin
            cols_eff = NCW'(2);
        end else if (int'(cols_used_reg) > MAX_COLS) begin
            cols_eff = NCW'(MAX_COLS);
        end else begin
            cols_eff = NCW'(cols_used_reg);
        end
        rows_nm1 = rows_eff - 1'b1;
        cols_nm1 = cols_eff - 1'b1;
    end

    // pipeline control
    logic [STAGES-1:0] vld_reg;
    logic [STAGES-2:0] op_reg;
    logic [5:0]        inb_reg;
    logic              en;

    assign en      = !vld_reg[STAGES-1] || m_ready;
    assign s_ready = en;
    assign m_valid = vld_reg[STAGES-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[STAGES-2:0], s_valid};
        end
    end

    // stage 1: offset from origin
    logic signed [32:0] lat_d, lon_d;
    assign lat_d = $signed({s_data.query_lat[31], s_data.query_lat})
                 - $signed({lat_origin_reg[31], lat_origin_reg});
    assign lon_d = $signed({s_data.query_lon[31], s_data.query_lon})
                 - $signed({lon_origin_reg[31], lon_origin_reg});

    logic [5:0]         s1_row_reg, s2_row_reg, s3_row_reg;
    logic [5:0]         s1_col_reg, s2_col_reg, s3_col_reg;
    logic signed [15:0] s1_cval_reg, s2_cval_reg, s3_cval_reg;
    logic               s1_latn_reg, s2_latn_reg, s3_latn_reg;
    logic               s1_lonn_reg, s2_lonn_reg, s3_lonn_reg;
    logic [32:0]        s1_latm_reg, s1_lonm_reg;
    logic [48:0]        s2_lat_hi_reg, s2_lat_lo_reg, s2_lon_hi_reg, s2_lon_lo_reg;
    logic [63:0]        s3_latp_reg, s3_lonp_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            op_reg      <= {op_reg[STAGES-3:0], s_data.opcode};
            s1_row_reg  <= s_data.cell_row;
            s1_col_reg  <= s_data.cell_col;
            s1_cval_reg <= s_data.cell_value;
            s1_latn_reg <= lat_d[32];
            s1_lonn_reg <= lon_d[32];
            s1_latm_reg <= lat_d[32] ? 33'(-lat_d) : 33'(lat_d);
            s1_lonm_reg <= lon_d[32] ? 33'(-lon_d) : 33'(lon_d);

            s2_row_reg    <= s1_row_reg;
            s2_col_reg    <= s1_col_reg;
            s2_cval_reg   <= s1_cval_reg;
            s2_latn_reg   <= s1_latn_reg;
            s2_lonn_reg   <= s1_lonn_reg;
            s2_lat_hi_reg <= s1_latm_reg * lat_scale_reg[31:16];
            s2_lat_lo_reg <= s1_latm_reg * lat_scale_reg[15:0];
            s2_lon_hi_reg <= s1_lonm_reg * lon_scale_reg[31:16];
            s2_lon_lo_reg <= s1_lonm_reg * lon_scale_reg[15:0];

            s3_row_reg  <= s2_row_reg;
            s3_col_reg  <= s2_col_reg;
            s3_cval_reg <= s2_cval_reg;
            s3_latn_reg <= s2_latn_reg;
            s3_lonn_reg <= s2_lonn_reg;
            s3_latp_reg <= 64'({s2_lat_hi_reg, 16'h0000}) + 64'(s2_lat_lo_reg);
            s3_lonp_reg <= 64'({s2_lon_hi_reg, 16'h0000}) + 64'(s2_lon_lo_reg);
        end
    end

    // stage 4: index, fraction, bounds, grid access
    logic [31:0]    lat_hi, lon_hi, lat_nm1_w, lon_nm1_w;
    logic           lat_oob_lo, lat_oob_hi, lat_far, lon_oob_lo, lon_oob_hi, lon_far;
    logic [IWR-1:0] lat_i;
    logic [IWC-1:0] lon_i;
    logic [16:0]    lat_u, lon_u;

    always_comb begin
        lat_hi     = s3_latp_reg[63:32];
        lat_nm1_w  = 32'(rows_nm1);
        lat_oob_lo = s3_latn_reg && (s3_latp_reg != 64'd0);
        lat_oob_hi = !s3_latn_reg && ((lat_hi > lat_nm1_w)
                     || (lat_hi == lat_nm1_w && s3_latp_reg[31:0] != 32'd0));
        lat_far    = !lat_oob_lo && (lat_hi >= lat_nm1_w);
        if (lat_far) begin
            lat_i = IWR'(rows_nm1 - 1'b1);
            lat_u = 17'h10000;
        end else if (lat_oob_lo) begin
            lat_i = '0;
            lat_u = '0;
        end else begin
            lat_i = IWR'(lat_hi);
            lat_u = {1'b0, s3_latp_reg[31:16]};
        end

        lon_hi     = s3_lonp_reg[63:32];
        lon_nm1_w  = 32'(cols_nm1);
        lon_oob_lo = s3_lonn_reg && (s3_lonp_reg != 64'd0);
        lon_oob_hi = !s3_lonn_reg && ((lon_hi > lon_nm1_w)
                     || (lon_hi == lon_nm1_w && s3_lonp_reg[31:0] != 32'd0));
        lon_far    = !lon_oob_lo && (lon_hi >= lon_nm1_w);
        if (lon_far) begin
            lon_i = IWC'(cols_nm1 - 1'b1);
            lon_u = 17'h10000;
        end else if (lon_oob_lo) begin
            lon_i = '0;
            lon_u = '0;
        end else begin
            lon_i = IWC'(lon_hi);
            lon_u = {1'b0, s3_lonp_reg[31:16]};
        end
    end

    logic              wr_any;
    logic signed [SW-1:0] wdata;
    logic signed [SW-1:0] bank_q [4];

    assign wr_any = en && vld_reg[2] && (op_reg[2] == OP_WRITE)
                 && (int'(s3_row_reg) < MAX_ROWS) && (int'(s3_col_reg) < MAX_COLS);
    assign wdata  = SW'(s3_cval_reg);

    for (genvar b = 0; b < 4; b++) begin : g_bank
        localparam bit RP = (b >= 2);
        localparam bit CP = ((b % 2) == 1);

        logic signed [SW-1:0] mem [BDEPTH];
        logic signed [SW-1:0] rd_reg;
        logic [IWR-1:0]       rsel;
        logic [IWC-1:0]       csel;
        logic [BAW-1:0]       raddr, waddr;
        logic                 wr;

        always_comb begin
            rsel  = (lat_i[0] == RP) ? lat_i : IWR'(lat_i + 1'b1);
            csel  = (lon_i[0] == CP) ? lon_i : IWC'(lon_i + 1'b1);
            raddr = {RHW'(rsel >> 1), CHW'(csel >> 1)};
            waddr = {RHW'(s3_row_reg >> 1), CHW'(s3_col_reg >> 1)};
            wr    = wr_any && (s3_row_reg[0] == RP) && (s3_col_reg[0] == CP);
        end

        always_ff @(posedge aclk) begin
            if (wr) begin
                mem[waddr] <= wdata;
            end
            if (en) begin
                rd_reg <= mem[raddr];
            end
        end

        assign bank_q[b] = rd_reg;
    end

    logic [16:0] s4_u_reg, s4_v_reg;
    logic        s4_i0_reg, s4_j0_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            s4_u_reg  <= lat_u;
            s4_v_reg  <= lon_u;
            s4_i0_reg <= lat_i[0];
            s4_j0_reg <= lon_i[0];
            inb_reg   <= {inb_reg[4:0], !lat_oob_lo && !lat_oob_hi
                                        && !lon_oob_lo && !lon_oob_hi};
        end
    end

    // stage 5: corner differences and first products
    logic signed [SW-1:0] v00, v10, v01, v11;
    logic signed [SW:0]   e0, e1;
    logic signed [SW+1:0] de;
    logic signed [17:0]   u_s, v_s;

    always_comb begin
        v00 = bank_q[{s4_i0_reg, s4_j0_reg}];
        v10 = bank_q[{~s4_i0_reg, s4_j0_reg}];
        v01 = bank_q[{s4_i0_reg, ~s4_j0_reg}];
        v11 = bank_q[{~s4_i0_reg, ~s4_j0_reg}];
        e0  = {v10[SW-1], v10} - {v00[SW-1], v00};
        e1  = {v11[SW-1], v11} - {v01[SW-1], v01};
        de  = {e1[SW], e1} - {e0[SW], e0};
        u_s = $signed({1'b0, s4_u_reg});
        v_s = $signed({1'b0, s4_v_reg});
    end

    logic signed [SW-1:0]  s5_v00_reg, s5_v01_reg;
    logic signed [SW:0]    s5_e0_reg;
    logic signed [SW+18:0] s5_m0_reg, s5_m1_reg;
    logic signed [SW+19:0] s5_m2_reg;
    logic [16:0]           s5_v_reg, s6_v_reg;

    // stage 6: lerp along rows, column difference, row gradient
    logic signed [AW-1:0] a0, a1;
    logic signed [AW-1:0] s6_a0_reg, s6_dv_reg, s6_du_reg;

    always_comb begin
        a0 = (AW'(s5_v00_reg) <<< 16) + AW'(s5_m0_reg);
        a1 = (AW'(s5_v01_reg) <<< 16) + AW'(s5_m1_reg);
    end

    // stage 7..9
    logic signed [SW+38:0] s7_vp_reg;
    logic signed [AW-1:0]  s7_a0_reg;
    logic [AW-1:0]         s7_dum_reg, s7_dvm_reg;
    logic                  s7_dun_reg, s7_dvn_reg, s8_dun_reg, s8_dvn_reg;
    logic                  s9_dun_reg, s9_dvn_reg;
    logic signed [VW-1:0]  s8_val_reg;
    logic [AW+15:0]        s8_gl_hi_reg, s8_gl_lo_reg, s8_gn_hi_reg, s8_gn_lo_reg;
    logic [VW-1:0]         val_mag;
    logic [VW:0]           val_rnd;
    logic [GW-1:0]         gl_rnd, gn_rnd;
    logic                  s9_valn_reg;
    logic [VQW-1:0]        s9_vq_reg;
    logic [GQW-1:0]        s9_glq_reg, s9_gnq_reg;

    always_comb begin
        val_mag = s8_val_reg[VW-1] ? VW'(-s8_val_reg) : VW'(s8_val_reg);
        val_rnd = (VW+1)'(val_mag) + (VW+1)'(24'h80_0000);
        gl_rnd  = (GW'(s8_gl_hi_reg) << 16) + GW'(s8_gl_lo_reg) + GW'(24'h80_0000);
        gn_rnd  = (GW'(s8_gn_hi_reg) << 16) + GW'(s8_gn_lo_reg) + GW'(24'h80_0000);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s5_v00_reg <= v00;
            s5_v01_reg <= v01;
            s5_e0_reg  <= e0;
            s5_m0_reg  <= u_s * e0;
            s5_m1_reg  <= u_s * e1;
            s5_m2_reg  <= v_s * de;
            s5_v_reg   <= s4_v_reg;

            s6_v_reg  <= s5_v_reg;
            s6_a0_reg <= a0;
            s6_dv_reg <= a1 - a0;
            s6_du_reg <= (AW'(s5_e0_reg) <<< 16) + AW'(s5_m2_reg);

            s7_vp_reg  <= $signed({1'b0, s6_v_reg}) * s6_dv_reg;
            s7_a0_reg  <= s6_a0_reg;
            s7_dun_reg <= s6_du_reg[AW-1];
            s7_dvn_reg <= s6_dv_reg[AW-1];
            s7_dum_reg <= s6_du_reg[AW-1] ? AW'(-s6_du_reg) : AW'(s6_du_reg);
            s7_dvm_reg <= s6_dv_reg[AW-1] ? AW'(-s6_dv_reg) : AW'(s6_dv_reg);

            s8_val_reg   <= (VW'(s7_a0_reg) <<< 16) + VW'(s7_vp_reg);
            s8_gl_hi_reg <= s7_dum_reg * lat_scale_reg[31:16];
            s8_gl_lo_reg <= s7_dum_reg * lat_scale_reg[15:0];
            s8_gn_hi_reg <= s7_dvm_reg * lon_scale_reg[31:16];
            s8_gn_lo_reg <= s7_dvm_reg * lon_scale_reg[15:0];
            s8_dun_reg   <= s7_dun_reg;
            s8_dvn_reg   <= s7_dvn_reg;

            s9_valn_reg <= s8_val_reg[VW-1];
            s9_vq_reg   <= val_rnd[VW:24];
            s9_glq_reg  <= gl_rnd[GW-1:24];
            s9_gnq_reg  <= gn_rnd[GW-1:24];
            s9_dun_reg  <= s8_dun_reg;
            s9_dvn_reg  <= s8_dvn_reg;
        end
    end

    // stage 10: saturation and result
    logic signed [23:0] val_sat;
    logic signed [31:0] gl_sat, gn_sat;
    bgi_out_t           res_next, res_reg;

    always_comb begin
        if (!s9_valn_reg) begin
            val_sat = (s9_vq_reg > VQW'(32'h007F_FFFF)) ? 24'sh7F_FFFF : s9_vq_reg[23:0];
        end else begin
            val_sat = (s9_vq_reg > VQW'(32'h0080_0000)) ? 24'sh80_0000 : -s9_vq_reg[23:0];
        end
        if (!s9_dun_reg) begin
            gl_sat = (s9_glq_reg > GQW'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF : s9_glq_reg[31:0];
        end else begin
            gl_sat = (s9_glq_reg > GQW'(32'h8000_0000)) ? 32'sh8000_0000 : -s9_glq_reg[31:0];
        end
        if (!s9_dvn_reg) begin
            gn_sat = (s9_gnq_reg > GQW'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF : s9_gnq_reg[31:0];
        end else begin
            gn_sat = (s9_gnq_reg > GQW'(32'h8000_0000)) ? 32'sh8000_0000 : -s9_gnq_reg[31:0];
        end

        res_next = '0;
        if (op_reg[STAGES-2] == OP_WRITE) begin
            res_next.is_write_ack = 1'b1;
        end else begin
            res_next.value     = val_sat;
            res_next.in_bounds = inb_reg[5];
            res_next.grad_lat  = inb_reg[5] ? gl_sat : '0;
            res_next.grad_lon  = inb_reg[5] ? gn_sat : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            res_reg <= res_next;
        end
    end

    assign m_data = res_reg;

`ifndef ASSERT_OFF
    a_ack_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.is_write_ack |-> m_data.value == 0 && m_data.grad_lat == 0
            && m_data.grad_lon == 0 && !m_data.in_bounds)
        else $error("write acknowledgement carries nonzero fields");
    a_oob_grad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.is_write_ack && !m_data.in_bounds |->
            m_data.grad_lat == 0 && m_data.grad_lon == 0)
        else $error("clamped query with nonzero gradient");
    a_frac_max: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[3] && s4_u_reg[16] |-> s4_u_reg[15:0] == 16'd0 && s4_v_reg <= 17'h10000)
        else $error("fraction above one");
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");
`endif

endmodule
